[rtl/core/mau_pkg.sv]
package mau_pkg;

   localparam int unsigned CMD_W = 4;
   localparam int unsigned OPND_W = 32;
   localparam int unsigned EXP_W = 63;
   localparam int unsigned RES_W = 31;

   localparam int unsigned FACT_DEPTH_DEF = 4096;
   localparam logic [RES_W-1:0] MODULUS_RESET = 31'd998244353;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 4'd0,
      CMD_SUB   = 4'd1,
      CMD_NEG   = 4'd2,
      CMD_MUL   = 4'd3,
      CMD_DIV   = 4'd4,
      CMD_POW   = 4'd5,
      CMD_INV   = 4'd6,
      CMD_FACT  = 4'd7,
      CMD_BINOM = 4'd8
   } cmd_type;

endpackage

[rtl/core/mau_if.sv]
interface mau_req_if;
   import mau_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [OPND_W-1:0]   operand_a;
   logic [OPND_W-1:0]   operand_b;
   logic [EXP_W-1:0]    exponent;

   modport source (output valid, command, operand_a, operand_b, exponent, input ready);
   modport sink (input valid, command, operand_a, operand_b, exponent, output ready);
endinterface

interface mau_rsp_if;
   import mau_pkg::*;
   logic                valid;
   logic                ready;
   logic [RES_W-1:0]    result_value;
   logic                error_flag;

   modport source (output valid, result_value, error_flag, input ready);
   modport sink (input valid, result_value, error_flag, output ready);
endinterface

[rtl/core/mau_ram.sv]
module mau_ram #(
   parameter int unsigned WIDTH = 31,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end
endmodule

[rtl/core/mau_mul.sv]
module mau_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mau_pkg::OPND_W-1:0]  mul_a,
   input  logic [mau_pkg::RES_W-1:0]   mul_b,
   input  logic [mau_pkg::RES_W-1:0]   modulus,
   output logic                        done,
   output logic [mau_pkg::RES_W-1:0]   product
);
   import mau_pkg::*;

   localparam int unsigned CW = $clog2(OPND_W);

   logic              busy_ff;
   logic [CW-1:0]     cnt_ff;
   logic [OPND_W-1:0] a_ff;
   logic [RES_W-1:0]  b_ff;
   logic [RES_W-1:0]  r_ff;
   logic              done_ff;
   logic [OPND_W-1:0] dbl;
   logic [OPND_W-1:0] dbl_red;
   logic [OPND_W-1:0] sum;
   logic [OPND_W-1:0] r_in;

   // one bit of a per cycle, msb first: r = 2r + bit*b, kept below modulus
   always_comb begin
      dbl = {r_ff, 1'b0};
      dbl_red = (dbl >= OPND_W'(modulus)) ? dbl - OPND_W'(modulus) : dbl;
      sum = dbl_red + (a_ff[OPND_W-1] ? OPND_W'(b_ff) : '0);
      r_in = (sum >= OPND_W'(modulus)) ? sum - OPND_W'(modulus) : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CW'(OPND_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            a_ff <= mul_a;
            b_ff <= mul_b;
            r_ff <= '0;
         end else if (busy_ff) begin
            r_ff <= r_in[RES_W-1:0];
            a_ff <= {a_ff[OPND_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(OPND_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign product = r_ff;
endmodule

[rtl/core/modular_arith_unit.sv]
// operands are reduced through the multiplier first; add, sub and neg need no further
// multiply, while mul, inv, div, pow and binomial do (pow up to a full 63-bit exponent)
// factorial and binomial add one multiply per new table entry; each modular multiply
// runs in one shared bit-serial multiplier
// one item in flight at a time; the next item is taken while a result waits
// reset: modulus 998244353, factorial table holds entry 0 only, no clearing pass
module modular_arith_unit #(
   parameter int unsigned FACT_DEPTH = mau_pkg::FACT_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [mau_pkg::RES_W-1:0] csr_write_data,
   mau_req_if.sink                   req,
   mau_rsp_if.source                 rsp
);
   import mau_pkg::*;

   localparam int unsigned AW = (FACT_DEPTH > 1) ? $clog2(FACT_DEPTH) : 1;
   localparam int unsigned FW = $clog2(FACT_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_FIN_MUL, S_POW_CHK, S_POW_MUL,
      S_POW_SQ, S_FEXT, S_FEXT_MUL, S_RD_ISSUE, S_RD_WAIT, S_DEN, S_DONE
   } state_type;

   state_type         state_ff;
   logic [RES_W-1:0]  modulus_ff;
   logic [FW-1:0]     filled_ff;
   logic [RES_W-1:0]  last_ff;
   cmd_type           cmd_ff;
   logic [OPND_W-1:0] ra_ff;
   logic [OPND_W-1:0] rb_ff;
   logic [EXP_W-1:0]  e_ff;
   logic [RES_W-1:0]  a_ff;
   logic [RES_W-1:0]  b_ff;
   logic [RES_W-1:0]  r_ff;
   logic              err_ff;
   logic [RES_W-1:0]  base_ff;
   logic [RES_W-1:0]  acc_ff;
   logic [EXP_W-1:0]  pexp_ff;
   logic [RES_W-1:0]  fn_ff;
   logic [RES_W-1:0]  fk_ff;
   logic [1:0]        phase_ff;
   logic              mul_start_ff;
   logic [OPND_W-1:0] mul_a_ff;
   logic [RES_W-1:0]  mul_b_ff;
   logic              rsp_valid_ff;
   logic [RES_W-1:0]  rsp_value_ff;
   logic              rsp_err_ff;

   logic              mul_done;
   logic [RES_W-1:0]  mul_p;
   logic              ram_we_in;
   logic [AW-1:0]     rd_idx_in;
   logic [RES_W-1:0]  ram_rdata;
   logic [RES_W-1:0]  rd_val_in;
   logic [OPND_W-1:0] diff_in;
   logic [EXP_W-1:0]  inv_exp_in;
   logic [OPND_W-1:0] add_in;
   logic [OPND_W-1:0] sub_in;
   logic [RES_W-1:0]  neg_in;
   logic              small_mod_in;
   logic              mul_start_in;
   logic              rsp_load_in;
   logic              rsp_valid_in;

   mau_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mul_a   (mul_a_ff),
      .mul_b   (mul_b_ff),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   mau_ram #(.WIDTH(RES_W), .DEPTH(FACT_DEPTH)) u_fact_ram (
      .clock        (clock),
      .write_enable (ram_we_in),
      .write_addr   (filled_ff[AW-1:0]),
      .write_data   (mul_p),
      .read_addr    (rd_idx_in),
      .read_data    (ram_rdata)
   );

   always_comb begin
      small_mod_in = (modulus_ff < RES_W'(2));
      diff_in = ra_ff - rb_ff;
      case (phase_ff)
         2'd0: rd_idx_in = ra_ff[AW-1:0];
         2'd1: rd_idx_in = rb_ff[AW-1:0];
         default: rd_idx_in = diff_in[AW-1:0];
      endcase
      // entry 0 is never written, it always reads as one
      rd_val_in = (rd_idx_in == '0) ? RES_W'(1) : ram_rdata;
      inv_exp_in = small_mod_in ? '0 : EXP_W'(modulus_ff - RES_W'(2));
      add_in = OPND_W'(a_ff) + OPND_W'(b_ff);
      if (add_in >= OPND_W'(modulus_ff)) begin
         add_in = add_in - OPND_W'(modulus_ff);
      end
      sub_in = OPND_W'(a_ff) + OPND_W'(modulus_ff) - OPND_W'(b_ff);
      if (sub_in >= OPND_W'(modulus_ff)) begin
         sub_in = sub_in - OPND_W'(modulus_ff);
      end
      neg_in = (a_ff == '0) ? '0 : modulus_ff - a_ff;
      ram_we_in = (state_ff == S_FEXT_MUL) && mul_done;
      rsp_load_in = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);
      rsp_valid_in = rsp_load_in || (rsp_valid_ff && !rsp.ready);
   end

   // states that hand a new operand pair to the multiplier
   always_comb begin
      case (state_ff)
         S_IDLE: mul_start_in = req.valid;
         S_RED_A, S_POW_MUL: mul_start_in = mul_done;
         S_DISPATCH: mul_start_in = (cmd_ff == CMD_MUL);
         S_POW_CHK: mul_start_in = (pexp_ff != '0) || (cmd_ff == CMD_DIV) ||
                                   (cmd_ff == CMD_BINOM);
         S_FEXT: mul_start_in = (OPND_W'(filled_ff) <= ra_ff);
         S_RD_WAIT: mul_start_in = (cmd_ff != CMD_FACT) &&
                                   !(phase_ff inside {2'd0, 2'd1});
         default: mul_start_in = 1'b0;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.error_flag = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         modulus_ff <= MODULUS_RESET;
         filled_ff <= FW'(1);
         last_ff <= RES_W'(1);
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= '0;
      end else begin
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            modulus_ff <= csr_write_data;
            filled_ff <= FW'(1);
            last_ff <= RES_W'(1);
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cmd_ff <= cmd_type'(req.command);
                  ra_ff <= req.operand_a;
                  rb_ff <= req.operand_b;
                  e_ff <= req.exponent;
                  err_ff <= 1'b0;
                  r_ff <= '0;
                  mul_a_ff <= req.operand_a;
                  mul_b_ff <= RES_W'(1);
                  state_ff <= S_RED_A;
               end
            end
            S_RED_A: begin
               if (mul_done) begin
                  a_ff <= mul_p;
                  mul_a_ff <= rb_ff;
                  mul_b_ff <= RES_W'(1);
                  state_ff <= S_RED_B;
               end
            end
            S_RED_B: begin
               if (mul_done) begin
                  b_ff <= mul_p;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               acc_ff <= RES_W'(1);
               phase_ff <= '0;
               case (cmd_ff)
                  CMD_ADD: begin
                     r_ff <= add_in[RES_W-1:0];
                     state_ff <= S_DONE;
                  end
                  CMD_SUB: begin
                     r_ff <= sub_in[RES_W-1:0];
                     state_ff <= S_DONE;
                  end
                  CMD_NEG: begin
                     r_ff <= neg_in;
                     state_ff <= S_DONE;
                  end
                  CMD_MUL: begin
                     mul_a_ff <= OPND_W'(a_ff);
                     mul_b_ff <= b_ff;
                     state_ff <= S_FIN_MUL;
                  end
                  CMD_DIV: begin
                     base_ff <= b_ff;
                     pexp_ff <= inv_exp_in;
                     state_ff <= S_POW_CHK;
                  end
                  CMD_POW: begin
                     base_ff <= a_ff;
                     pexp_ff <= e_ff;
                     state_ff <= S_POW_CHK;
                  end
                  CMD_INV: begin
                     base_ff <= a_ff;
                     pexp_ff <= inv_exp_in;
                     state_ff <= S_POW_CHK;
                  end
                  CMD_FACT, CMD_BINOM: begin
                     if ((ra_ff >= OPND_W'(FACT_DEPTH)) ||
                         ((cmd_ff == CMD_BINOM) && (rb_ff > ra_ff))) begin
                        err_ff <= 1'b1;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_FEXT;
                     end
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_FIN_MUL: begin
               if (mul_done) begin
                  r_ff <= mul_p;
                  state_ff <= S_DONE;
               end
            end
            S_POW_CHK: begin
               if (pexp_ff == '0) begin
                  case (cmd_ff)
                     CMD_DIV: begin
                        mul_a_ff <= OPND_W'(a_ff);
                        mul_b_ff <= acc_ff;
                        state_ff <= S_FIN_MUL;
                     end
                     CMD_BINOM: begin
                        mul_a_ff <= OPND_W'(fn_ff);
                        mul_b_ff <= acc_ff;
                        state_ff <= S_FIN_MUL;
                     end
                     default: begin
                        r_ff <= acc_ff;
                        state_ff <= S_DONE;
                     end
                  endcase
               end else if (pexp_ff[0]) begin
                  mul_a_ff <= OPND_W'(acc_ff);
                  mul_b_ff <= base_ff;
                  state_ff <= S_POW_MUL;
               end else begin
                  mul_a_ff <= OPND_W'(base_ff);
                  mul_b_ff <= base_ff;
                  state_ff <= S_POW_SQ;
               end
            end
            S_POW_MUL: begin
               if (mul_done) begin
                  acc_ff <= mul_p;
                  mul_a_ff <= OPND_W'(base_ff);
                  mul_b_ff <= base_ff;
                  state_ff <= S_POW_SQ;
               end
            end
            S_POW_SQ: begin
               if (mul_done) begin
                  base_ff <= mul_p;
                  pexp_ff <= {1'b0, pexp_ff[EXP_W-1:1]};
                  state_ff <= S_POW_CHK;
               end
            end
            S_FEXT: begin
               // extend the table one entry at a time up to n
               if (OPND_W'(filled_ff) <= ra_ff) begin
                  mul_a_ff <= OPND_W'(filled_ff);
                  mul_b_ff <= last_ff;
                  state_ff <= S_FEXT_MUL;
               end else begin
                  state_ff <= S_RD_ISSUE;
               end
            end
            S_FEXT_MUL: begin
               if (mul_done) begin
                  last_ff <= mul_p;
                  filled_ff <= filled_ff + 1'b1;
                  state_ff <= S_FEXT;
               end
            end
            S_RD_ISSUE: begin
               state_ff <= S_RD_WAIT;
            end
            S_RD_WAIT: begin
               if (cmd_ff == CMD_FACT) begin
                  r_ff <= rd_val_in;
                  state_ff <= S_DONE;
               end else begin
                  case (phase_ff)
                     2'd0: begin
                        fn_ff <= rd_val_in;
                        phase_ff <= 2'd1;
                        state_ff <= S_RD_ISSUE;
                     end
                     2'd1: begin
                        fk_ff <= rd_val_in;
                        phase_ff <= 2'd2;
                        state_ff <= S_RD_ISSUE;
                     end
                     default: begin
                        mul_a_ff <= OPND_W'(fk_ff);
                        mul_b_ff <= rd_val_in;
                        state_ff <= S_DEN;
                     end
                  endcase
               end
            end
            S_DEN: begin
               if (mul_done) begin
                  base_ff <= mul_p;
                  pexp_ff <= inv_exp_in;
                  state_ff <= S_POW_CHK;
               end
            end
            S_DONE: begin
               if (rsp_load_in) begin
                  rsp_value_ff <= small_mod_in ? '0 : r_ff;
                  rsp_err_ff <= err_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule
